[hdl/dte_pkg.sv]
// Shared types, constants and helper functions for the date-time text to epoch unit.
// No dependencies; compiled before every other file of the block.
package dte_pkg;

    localparam int NumFields = 7;

    // character codes
    localparam logic [7:0] CharNul   = 8'h00;
    localparam logic [7:0] CharDash  = 8'h2D;
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharColon = 8'h3A;
    localparam logic [7:0] CharDot   = 8'h2E;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;

    localparam logic [2:0]  MaxDigits   = 3'd4;
    localparam logic [2:0]  FieldStop   = 3'd7;  // all seven fields used up
    localparam logic [2:0]  FracField   = 3'd6;
    localparam logic [13:0] EpochYear   = 14'd1970;
    localparam logic [12:0] Leaps1969   = 13'd477; // 1969/4 - 1969/100 + 1969/400
    localparam logic [8:0]  DaysPerYear = 9'd365;
    localparam logic [11:0] SecPerHour  = 12'd3600;
    localparam logic [5:0]  SecPerMin   = 6'd60;
    localparam logic [16:0] ZoneReset   = 17'd28800;
    localparam logic [12:0] Recip100    = 13'd5243;  // 2^19 / 100, exact below 43690
    localparam logic [12:0] Recip10     = 13'd6554;  // 2^16 / 10, exact below 16384

    typedef logic [6:0][13:0] field_vals_t;
    typedef logic [6:0][2:0]  field_cnts_t;

    // snapshot of the collected text
    typedef struct packed {
        field_vals_t vals;
        field_cnts_t cnts;
        logic [2:0]  idx;
        logic        dash;
    } snap_t;

    // aligned fields
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;   // clamped to 13
        logic [13:0] day;
        logic [13:0] hour;
        logic [13:0] minute;
        logic [13:0] second;
        logic [13:0] frac_val;
        logic [2:0]  frac_cnt;
    } fields_t;

    // calendar partial terms
    typedef struct packed {
        logic        after_epoch;
        logic [21:0] year_days;
        logic [11:0] ym1_q4;
        logic [7:0]  ym1_q100;
        logic [7:0]  y_q100;
        logic        y_div4;
        logic [13:0] year;
        logic [8:0]  cum_days;
        logic        month_gt2;
        logic [13:0] day;
        logic [25:0] hour_sec;
        logic [19:0] min_sec;
        logic [13:0] second;
        logic [9:0]  frac;
    } terms_t;

    typedef struct packed {
        logic signed [23:0] days;
        logic signed [27:0] hms_off;
        logic [9:0]         frac;
    } days_t;

    typedef struct packed {
        logic signed [39:0] day_sec;
        logic signed [27:0] hms_off;
        logic [9:0]         frac;
    } secs_t;

    // floor(x / 100) by reciprocal
    function automatic logic [7:0] div100(input logic [13:0] x);
        logic [26:0] prod;
        prod = 27'(x) * 27'(Recip100);
        return prod[26:19];
    endfunction

    // days in the months before month m (m clamped to 0..13)
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            4'd13:   d = 9'd365;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[hdl/dte_char_if.sv]
// Character channel: one text character per beat with its end-of-text flag.
// Depends on nothing.
interface dte_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       is_last;

    modport source (output valid, output text_char, output is_last, input ready);
    modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

[hdl/dte_epoch_if.sv]
// Result channel: epoch seconds and millisecond fraction per beat.
// Depends on nothing.
interface dte_epoch_if;
    logic               valid;
    logic               ready;
    logic signed [38:0] epoch_seconds;
    logic [9:0]         fraction_ms;

    modport source (output valid, output epoch_seconds, output fraction_ms, input ready);
    modport sink   (input valid, input epoch_seconds, input fraction_ms, output ready);
endinterface

[hdl/dte_cfg_if.sv]
// Configuration write channel: zone offset in seconds per beat.
// Depends on nothing.
interface dte_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] zone_offset_seconds;

    modport source (output valid, output zone_offset_seconds, input ready);
    modport sink   (input valid, input zone_offset_seconds, output ready);
endinterface

[hdl/datetime_text_to_epoch_unit.sv]
// The snapshot taken with the last character passes stages 2 to 5 and the output register.
// Throughput: one character beat per cycle; back-pressure only when every stage holds a beat.
// The rate is set by the per-character digit accumulate (one multiply-by-ten-add) at the input.
// Reset (rst_n, async, active low): collection cleared, pipeline empty, zone offset 28800 s.
// Depends on dte_pkg and the dte_char_if, dte_epoch_if and dte_cfg_if interfaces.
module datetime_text_to_epoch_unit
    import dte_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    dte_cfg_if.sink      cfg,
    dte_char_if.sink     text,
    dte_epoch_if.source  result
);

    // ------------------------------------------------------------------
    // Configuration: zone offset register, always ready.
    // ------------------------------------------------------------------
    logic signed [16:0] zone_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= $signed(ZoneReset);
        end
        else if (cfg.valid)
        begin
            zone_reg <= cfg.zone_offset_seconds;
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage loads when empty or when the next one
    // moves on, so bubbles are squeezed out while the output is stalled.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;
    logic en1, en2, en3, en4, en5, en_out;
    logic take, take_last;

    assign en_out    = !out_valid_reg || result.ready;
    assign en5       = !v5_reg || en_out;
    assign en4       = !v4_reg || en5;
    assign en3       = !v3_reg || en4;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign text.ready = en1;
    assign take      = text.valid && text.ready;
    assign take_last = take && text.is_last;

    // ------------------------------------------------------------------
    // Character collection. The char beat is folded in first; on the last
    // beat the updated fields go to the snapshot and collection clears.
    // ------------------------------------------------------------------
    field_vals_t val_reg, val_next;
    field_cnts_t cnt_reg, cnt_next;
    logic [2:0]  idx_reg, idx_next;
    logic        dash_reg, dash_next;
    logic        ended_reg, ended_next;
    logic        is_sep, is_digit;
    logic [3:0]  digit;
    snap_t       snap;

    assign is_sep   = (text.text_char == CharDash) || (text.text_char == CharSpace) ||
                      (text.text_char == CharColon) || (text.text_char == CharDot);
    assign is_digit = (text.text_char >= CharZero) && (text.text_char <= CharNine);
    assign digit    = text.text_char[3:0];   // low nibble of '0'..'9'

    always_comb
    begin
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        dash_next  = dash_reg;
        ended_next = ended_reg;
        if (take && !ended_reg)
        begin
            if (text.text_char == CharNul)
            begin
                ended_next = 1'b1;
            end
            else if (idx_reg != FieldStop)
            begin
                if (is_sep)
                begin
                    if (text.text_char == CharDash)
                    begin
                        dash_next = 1'b1;
                    end
                    idx_next = idx_reg + 3'd1;
                end
                else if (is_digit)
                begin
                    for (int i = 0; i < NumFields; i++)
                    begin
                        if ((idx_reg == 3'(i)) && (cnt_reg[i] < MaxDigits))
                        begin
                            val_next[i] = {val_reg[i][10:0], 3'b000}
                                        + {val_reg[i][12:0], 1'b0}
                                        + 14'(digit);
                            cnt_next[i] = cnt_reg[i] + 3'd1;
                        end
                    end
                end
            end
        end
        snap.vals = val_next;
        snap.cnts = cnt_next;
        snap.idx  = idx_next;
        snap.dash = dash_next;
        if (take_last)
        begin
            val_next   = '0;
            cnt_next   = '0;
            idx_next   = '0;
            dash_next  = 1'b0;
            ended_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            dash_reg  <= 1'b0;
            ended_reg <= 1'b0;
        end
        else
        begin
            val_reg   <= val_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            dash_reg  <= dash_next;
            ended_reg <= ended_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: alignment. Without a dash and with fewer than six
    // separators the used fields slide up so the last one is the fraction.
    // ------------------------------------------------------------------
    snap_t       s1_reg;
    field_vals_t av;
    logic [2:0]  shift;
    logic        aligned;
    logic [2:0]  frac_cnt;
    fields_t     s2_next, s2_reg;

    assign aligned = !s1_reg.dash && (s1_reg.idx < FracField);
    assign shift   = FracField - s1_reg.idx;

    always_comb
    begin
        av       = s1_reg.vals;
        frac_cnt = s1_reg.cnts[FracField];
        if (aligned)
        begin
            frac_cnt = s1_reg.cnts[s1_reg.idx];
            for (int j = 0; j < NumFields; j++)
            begin
                if (3'(j) >= shift)
                begin
                    av[j] = s1_reg.vals[3'(j) - shift];
                end
                else
                begin
                    av[j] = '0;
                end
            end
        end
        s2_next.year     = av[0];
        s2_next.month    = (av[1] > 14'd13) ? 4'd13 : av[1][3:0];
        s2_next.day      = av[2];
        s2_next.hour     = av[3];
        s2_next.minute   = av[4];
        s2_next.second   = av[5];
        s2_next.frac_val = av[6];
        s2_next.frac_cnt = frac_cnt;
    end

    // ------------------------------------------------------------------
    // Stage 3: year terms, quotients for the leap-year count, month table,
    // hour and minute products, fraction scaling to milliseconds.
    // ------------------------------------------------------------------
    terms_t      s3_next, s3_reg;
    logic [13:0] ym1;
    logic [12:0] yoff;
    logic [25:0] frac_div;

    assign ym1      = s2_reg.year - 14'd1;
    assign yoff     = 13'(s2_reg.year - EpochYear);
    assign frac_div = 26'(s2_reg.frac_val) * 26'(Recip10);

    always_comb
    begin
        s3_next.after_epoch = s2_reg.year > EpochYear;
        s3_next.year_days   = s3_next.after_epoch ? 22'(yoff) * 22'(DaysPerYear) : '0;
        s3_next.ym1_q4      = ym1[13:2];
        s3_next.ym1_q100    = div100(ym1);
        s3_next.y_q100      = div100(s2_reg.year);
        s3_next.y_div4      = s2_reg.year[1:0] == 2'b00;
        s3_next.year        = s2_reg.year;
        s3_next.cum_days    = cum_days(s2_reg.month);
        s3_next.month_gt2   = s2_reg.month > 4'd2;
        s3_next.day         = s2_reg.day;
        s3_next.hour_sec    = 26'(s2_reg.hour) * 26'(SecPerHour);
        s3_next.min_sec     = 20'(s2_reg.minute) * 20'(SecPerMin);
        s3_next.second      = s2_reg.second;
        // digits over 10^count, truncated to ms
        unique case (s2_reg.frac_cnt)
            3'd1:    s3_next.frac = 10'(s2_reg.frac_val * 14'd100);
            3'd2:    s3_next.frac = 10'(s2_reg.frac_val * 14'd10);
            3'd3:    s3_next.frac = s2_reg.frac_val[9:0];
            3'd4:    s3_next.frac = frac_div[25:16];
            default: s3_next.frac = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 4: day count and time-of-day seconds less the zone offset.
    // ------------------------------------------------------------------
    days_t       s4_next, s4_reg;
    logic [12:0] leaps;
    logic        rem100_zero;
    logic        leap_day;
    logic [23:0] day_sum;
    logic [25:0] hms;

    always_comb
    begin
        leaps = 13'(s3_reg.ym1_q4) - 13'(s3_reg.ym1_q100)
              + 13'(s3_reg.ym1_q100[7:2]) - Leaps1969;
        if (!s3_reg.after_epoch)
        begin
            leaps = '0;
        end
        rem100_zero = s3_reg.year == (14'(s3_reg.y_q100) * 14'd100);
        leap_day    = s3_reg.month_gt2 && s3_reg.y_div4 &&
                      (!rem100_zero || (s3_reg.y_q100[1:0] == 2'b00));
        day_sum     = 24'(s3_reg.year_days) + 24'(leaps) + 24'(s3_reg.cum_days)
                    + 24'(leap_day) + 24'(s3_reg.day);
        hms         = s3_reg.hour_sec + 26'(s3_reg.min_sec) + 26'(s3_reg.second);
        s4_next.days    = $signed(day_sum) - 24'sd1;
        s4_next.hms_off = $signed({2'b00, hms}) - $signed({{11{zone_reg[16]}}, zone_reg});
        s4_next.frac    = s3_reg.frac;
    end

    // ------------------------------------------------------------------
    // Stage 5: days to seconds. Output stage: final sum, 39-bit wrap.
    // ------------------------------------------------------------------
    secs_t              s5_next, s5_reg;
    logic signed [39:0] epoch_full;

    assign s5_next.day_sec = $signed({{16{s4_reg.days[23]}}, s4_reg.days}) * 40'sd86400;
    assign s5_next.hms_off = s4_reg.hms_off;
    assign s5_next.frac    = s4_reg.frac;

    assign epoch_full = s5_reg.day_sec + $signed({{12{s5_reg.hms_off[27]}}, s5_reg.hms_off});

    logic signed [38:0] epoch_reg;
    logic [9:0]         frac_reg;

    assign result.valid         = out_valid_reg;
    assign result.epoch_seconds = epoch_reg;
    assign result.fraction_ms   = frac_reg;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= take_last;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v5_reg;
            end
        end
    end

    // stage payloads, no reset
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= snap;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            s3_reg <= s3_next;
        end
        if (en4)
        begin
            s4_reg <= s4_next;
        end
        if (en5)
        begin
            s5_reg <= s5_next;
        end
    end

    // output register: final sum of the s5 beat, moves with out_valid_reg
    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            epoch_reg <= epoch_full[38:0];
            frac_reg  <= s5_reg.frac;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        take_last |=> (idx_reg == 3'd0) && !dash_reg && !ended_reg)
        else $error("collection not cleared after last beat");

    a_snap_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (en1 && !take_last) |=> !v1_reg)
        else $error("snapshot stage filled without a last beat");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !text.ready |-> (out_valid_reg && !result.ready))
        else $error("input stalled while output free");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (frac_reg <= 10'd999))
        else $error("fraction above 999 ms");

endmodule
